@@ rtl/ba_pkg.sv @@
package ba_pkg;
	localparam int MEM_BYTES_C = 4096;
	localparam int LEVELS_C = 13;

	localparam logic [1:0] MODE_INIT = 2'd0;
	localparam logic [1:0] MODE_ALLOC = 2'd1;
	localparam logic [1:0] MODE_FREE = 2'd2;

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_FREE = 2'd1;
	localparam logic [1:0] ST_USED = 2'd2;

	localparam logic [3:0] CFG_MEM_SIZE = 4'd0;
	localparam logic [3:0] CFG_SMALLEST = 4'd1;
	localparam logic [3:0] CFG_LARGEST = 4'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [12:0] request_size;
		logic [11:0] block_address;
	} ba_req_t;

	typedef struct packed {
		logic        status;
		logic [11:0] granted_address;
		logic [11:0] wasted_bytes;
		logic [12:0] bytes_in_use;
		logic [12:0] bytes_free;
		logic [12:0] bytes_inside_waste;
	} ba_rsp_t;

	// per-address entry of the block table
	typedef struct packed {
		logic [1:0]  st;
		logic [3:0]  lvl;
		logic        nvalid;
		logic [11:0] nxt;
		logic [12:0] req;
	} ba_ent_t;

	// memory port bundle between sequencer and table
	typedef struct packed {
		logic        rd;
		logic [11:0] raddr;
		logic        we;
		logic [11:0] waddr;
		ba_ent_t     wdata;
	} ba_mem_req_t;
endpackage

@@ rtl/ba_table.sv @@
module ba_table (
	input  logic                clk,
	input  ba_pkg::ba_mem_req_t mreq,
	output ba_pkg::ba_ent_t     rdata
);
	import ba_pkg::*;

	ba_ent_t mem [MEM_BYTES_C];

	always_ff @(posedge clk) begin
		if (mreq.we) mem[mreq.waddr] <= mreq.wdata;
		if (mreq.rd) rdata <= mem[mreq.raddr];
	end
endmodule

@@ rtl/buddy_allocator.sv @@
// channel  | signals                     | transfer
// ---------+-----------------------------+--------------------------------
// request  | start, busy, req            | start high while busy low
// result   | done, rsp                   | done high for one cycle
// config   | cfg_we, cfg_index, cfg_data | cfg_we high, no wait
//
// after reset the table is swept clear, one entry a cycle.
// init sweeps the table again, then carves: each block passes CARVE, PUSHRD
// and PUSHWR, and each level stepped down takes one more CARVE step.
// allocate and free step through the table per level and per list entry walked:
// the registered read of the table sets the pace.
// the receiver cannot stall; results are shown for one cycle only.
module buddy_allocator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ba_pkg::ba_req_t req,
	output logic            done,
	output ba_pkg::ba_rsp_t rsp,
	input  logic            cfg_we,
	input  logic [3:0]      cfg_index,
	input  logic [12:0]     cfg_data
);
	import ba_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE   = 16'b0000000000000001,
		S_CLEAR  = 16'b0000000000000010,
		S_CARVE  = 16'b0000000000000100,
		S_PUSHRD = 16'b0000000000001000,
		S_PUSHWR = 16'b0000000000010000,
		S_POP    = 16'b0000000000100000,
		S_POPWR  = 16'b0000000001000000,
		S_SPLIT  = 16'b0000000010000000,
		S_FRD    = 16'b0000000100000000,
		S_FCHK   = 16'b0000001000000000,
		S_BRD    = 16'b0000010000000000,
		S_BCHK   = 16'b0000100000000000,
		S_WALK   = 16'b0001000000000000,
		S_UNLINK = 16'b0010000000000000,
		S_BCLR   = 16'b0100000000000000,
		S_DONE   = 16'b1000000000000000
	} state_t;

	state_t state_q;
	logic [12:0] mem_size_q;
	logic [3:0]  lo_cfg_q, hi_cfg_q;
	logic [12:0] ctr_q;       // sweep address / remaining bytes
	logic [12:0] addr_q;      // carve address
	logic [3:0]  lv_q, tlv_q, j_q;
	logic [11:0] a_q, b_q, prev_q, cur_q, pa_q;
	logic        have_prev_q, carving_q, alloc_q;
	logic [12:0] sz_q;
	logic [11:0] head_q [LEVELS_C];
	logic [11:0] tail_q [LEVELS_C];
	logic        lvalid_q [LEVELS_C];
	logic [12:0] use_q, free_q, waste_q;
	ba_rsp_t     rsp_q;
	logic        done_q;
	ba_mem_req_t mreq;
	ba_ent_t     rdata;

	ba_table u_table (.clk(clk), .mreq(mreq), .rdata(rdata));

	logic [3:0] lo, hi, rlv;
	logic [12:0] rem_c;
	logic [3:0] jsel;
	logic       jfound;
	logic [11:0] amin;

	always_comb begin
		lo = (lo_cfg_q > 4'd12) ? 4'd12 : lo_cfg_q;
		hi = (hi_cfg_q > 4'd12) ? 4'd12 : hi_cfg_q;
		rem_c = (mem_size_q > 13'd4096) ? 13'd4096 : mem_size_q;
		rlv = 4'd13;
		for (int i = 12; i >= 0; i--)
			if (req.request_size <= (13'd1 << i)) rlv = 4'(i);
		// nearest non-empty level at or above lv_q, up to hi
		jsel = 4'd0;
		jfound = 1'b0;
		for (int i = 12; i >= 0; i--)
			if (4'(i) >= lv_q && 4'(i) <= hi && lvalid_q[i]) begin
				jsel = 4'(i);
				jfound = 1'b1;
			end
		// merged block starts at the lower of the two buddies
		amin = (b_q < a_q) ? b_q : a_q;
	end

	// table port per state; push of a_q at level tlv_q: read-modify of the old tail in PUSHRD/PUSHWR
	always_comb begin
		mreq = '0;
		case (state_q)
			S_CLEAR: begin
				mreq.we = 1'b1;
				mreq.waddr = ctr_q[11:0];
			end
			S_PUSHRD: begin
				mreq.we = 1'b1;
				mreq.waddr = a_q;
				mreq.wdata.st = ST_FREE;
				mreq.wdata.lvl = tlv_q;
				if (lvalid_q[tlv_q]) begin
					mreq.rd = 1'b1;
					mreq.raddr = tail_q[tlv_q];
				end
			end
			S_PUSHWR: begin
				mreq.we = lvalid_q[tlv_q];
				mreq.waddr = tail_q[tlv_q];
				mreq.wdata = rdata;
				mreq.wdata.nvalid = 1'b1;
				mreq.wdata.nxt = a_q;
				// old tail was written in PUSHRD when equal to a_q: not possible
			end
			S_POP: begin
				mreq.rd = 1'b1;
				mreq.raddr = head_q[jsel];
			end
			S_POPWR: begin
				mreq.we = 1'b1;
				mreq.waddr = pa_q;
				mreq.wdata.st = ST_USED;
				mreq.wdata.lvl = lv_q;
				mreq.wdata.req = sz_q;
			end
			S_FRD: begin
				mreq.rd = 1'b1;
				mreq.raddr = a_q;
			end
			S_FCHK: begin
				if (rdata.st == ST_USED) begin
					mreq.we = 1'b1;
					mreq.waddr = a_q;
					mreq.wdata = rdata;
					mreq.wdata.st = ST_NONE;
				end
			end
			S_BRD: begin
				mreq.rd = 1'b1;
				mreq.raddr = b_q;
			end
			S_WALK: begin
				mreq.rd = 1'b1;
				mreq.raddr = cur_q;
			end
			S_UNLINK: begin
				// rdata holds entry cur_q; relink the previous entry past the buddy
				if (cur_q == b_q && have_prev_q) begin
					mreq.we = 1'b1;
					mreq.waddr = prev_q;
					mreq.wdata.st = ST_FREE;
					mreq.wdata.lvl = lv_q;
					mreq.wdata.nvalid = rdata.nvalid;
					mreq.wdata.nxt = rdata.nxt;
				end
			end
			S_BCLR: begin
				// buddy is absorbed into the merged block
				mreq.we = 1'b1;
				mreq.waddr = b_q;
			end
			default: ;
		endcase
	end

	// walk keeps only the prev address; the unlink write rebuilds that entry as free at lv_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			mem_size_q <= 13'd4096;
			lo_cfg_q <= 4'd0;
			hi_cfg_q <= 4'd12;
			ctr_q <= '0;
			done_q <= 1'b0;
			carving_q <= 1'b0;
			alloc_q <= 1'b0;
			use_q <= '0;
			free_q <= '0;
			waste_q <= '0;
			for (int i = 0; i < LEVELS_C; i++) lvalid_q[i] <= 1'b0;
		end else begin
			done_q <= (state_q == S_DONE);
			if (cfg_we) begin
				case (cfg_index)
					CFG_MEM_SIZE: mem_size_q <= cfg_data;
					CFG_SMALLEST: lo_cfg_q <= cfg_data[3:0];
					CFG_LARGEST: hi_cfg_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						rsp_q <= '{1'b1, 12'd0, 12'd0, use_q, free_q, waste_q};
						case (req.mode)
							MODE_INIT: begin
								for (int i = 0; i < LEVELS_C; i++) lvalid_q[i] <= 1'b0;
								use_q <= '0;
								free_q <= '0;
								waste_q <= '0;
								ctr_q <= '0;
								carving_q <= 1'b1;
								state_q <= S_CLEAR;
							end
							MODE_ALLOC: begin
								sz_q <= req.request_size;
								lv_q <= (rlv < lo) ? lo : rlv;
								if (req.request_size == 13'd0 || rlv > hi ||
									lo > hi) state_q <= S_DONE;
								else state_q <= S_POP;
							end
							MODE_FREE: begin
								a_q <= req.block_address;
								state_q <= S_FRD;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_CLEAR: begin
					if (ctr_q == 13'(MEM_BYTES_C - 1)) begin
						if (carving_q) begin
							ctr_q <= rem_c;
							addr_q <= '0;
							lv_q <= hi;
							state_q <= S_CARVE;
						end else state_q <= S_IDLE;
					end else ctr_q <= ctr_q + 13'd1;
				end
				S_CARVE: begin
					if (lv_q < lo || lv_q > hi || lo > hi) begin
						free_q <= addr_q;
						rsp_q <= '{1'b0, 12'd0,
							(ctr_q > 13'd4095) ? 12'd4095 : ctr_q[11:0],
							13'd0, addr_q, 13'd0};
						state_q <= S_DONE;
					end else if (ctr_q >= (13'd1 << lv_q)) begin
						a_q <= addr_q[11:0];
						tlv_q <= lv_q;
						addr_q <= addr_q + (13'd1 << lv_q);
						ctr_q <= ctr_q - (13'd1 << lv_q);
						alloc_q <= 1'b0;
						state_q <= S_PUSHRD;
					end else if (lv_q == 4'd0) begin
						lv_q <= 4'd15;
					end else lv_q <= lv_q - 4'd1;
				end
				S_PUSHRD: state_q <= S_PUSHWR;
				S_PUSHWR: begin
					if (!lvalid_q[tlv_q]) head_q[tlv_q] <= a_q;
					lvalid_q[tlv_q] <= 1'b1;
					tail_q[tlv_q] <= a_q;
					if (carving_q) state_q <= S_CARVE;
					else if (alloc_q) state_q <= S_SPLIT;
					else state_q <= S_DONE;
				end
				S_POP: begin
					// issues read of head; choose level
					if (!jfound) state_q <= S_DONE;
					else begin
						j_q <= jsel;
						pa_q <= head_q[jsel];
						state_q <= S_POPWR;
					end
				end
				S_POPWR: begin
					if (rdata.nvalid) head_q[j_q] <= rdata.nxt;
					else lvalid_q[j_q] <= 1'b0;
					alloc_q <= 1'b1;
					state_q <= S_SPLIT;
				end
				S_SPLIT: begin
					if (j_q > lv_q) begin
						a_q <= pa_q ^ (12'd1 << (j_q - 4'd1));
						tlv_q <= j_q - 4'd1;
						j_q <= j_q - 4'd1;
						state_q <= S_PUSHRD;
					end else begin
						use_q <= use_q + (13'd1 << lv_q);
						free_q <= free_q - (13'd1 << lv_q);
						waste_q <= waste_q + (13'd1 << lv_q) - sz_q;
						rsp_q <= '{1'b0, pa_q, 12'd0, use_q + (13'd1 << lv_q),
							free_q - (13'd1 << lv_q),
							waste_q + (13'd1 << lv_q) - sz_q};
						alloc_q <= 1'b0;
						state_q <= S_DONE;
					end
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (rdata.st != ST_USED) state_q <= S_DONE;
					else begin
						lv_q <= rdata.lvl;
						use_q <= use_q - (13'd1 << rdata.lvl);
						free_q <= free_q + (13'd1 << rdata.lvl);
						waste_q <= waste_q - ((13'd1 << rdata.lvl) - rdata.req);
						rsp_q <= '{1'b0, 12'd0, 12'd0, use_q - (13'd1 << rdata.lvl),
							free_q + (13'd1 << rdata.lvl),
							waste_q - ((13'd1 << rdata.lvl) - rdata.req)};
						b_q <= a_q ^ (12'd1 << rdata.lvl);
						state_q <= (rdata.lvl < hi) ? S_BRD : S_PUSHRD;
						tlv_q <= rdata.lvl;
					end
				end
				S_BRD: state_q <= S_BCHK;
				S_BCHK: begin
					if (rdata.st != ST_FREE || rdata.lvl != lv_q ||
						!lvalid_q[lv_q]) begin
						tlv_q <= lv_q;
						state_q <= S_PUSHRD;
					end else begin
						cur_q <= head_q[lv_q];
						have_prev_q <= 1'b0;
						state_q <= S_WALK;
					end
				end
				S_WALK: state_q <= S_UNLINK;
				S_UNLINK: begin
					if (cur_q == b_q) begin
						if (!have_prev_q) begin
							if (rdata.nvalid) head_q[lv_q] <= rdata.nxt;
							else lvalid_q[lv_q] <= 1'b0;
						end else if (tail_q[lv_q] == cur_q) tail_q[lv_q] <= prev_q;
						state_q <= S_BCLR;
					end else if (!rdata.nvalid) begin
						tlv_q <= lv_q;
						state_q <= S_PUSHRD;
					end else begin
						prev_q <= cur_q;
						have_prev_q <= 1'b1;
						cur_q <= rdata.nxt;
						state_q <= S_WALK;
					end
				end
				S_BCLR: begin
					// step up one level with the merged block
					a_q <= amin;
					lv_q <= lv_q + 4'd1;
					b_q <= amin ^ (12'd1 << (lv_q + 4'd1));
					if (lv_q + 4'd1 < hi) state_q <= S_BRD;
					else begin
						tlv_q <= lv_q + 4'd1;
						state_q <= S_PUSHRD;
					end
				end
				S_DONE: begin
					carving_q <= 1'b0;
					alloc_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;
endmodule
